// ===== sv/pcc_pkg.sv =====
`default_nettype none
package pcc_pkg;

    // Fixed widths of the channel fields.
    localparam int IN_COORD_W = 12;
    localparam int SCORE_W    = 15;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // Score search runs over 0 .. SEARCH_HI, doubled scale for half-step rounding.
    localparam int SRCH_W    = 14;
    localparam int SEARCH_HI = 10000;
    localparam int SCALE2    = 20000;
    // Square of the largest odd search value fits in this many bits.
    localparam int ODD2_W    = 30;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FLAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SKIP_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_AXIS = 2'd1;

    // Multiplier jobs, in the order one axis runs them.
    typedef enum logic [3:0] {
        OP_N_SQM,
        OP_SM_SM,
        OP_N_SQR,
        OP_SR_SR,
        OP_N_CROSS,
        OP_SM_SR,
        OP_D1_D2,
        OP_K_MAG,
        OP_T_T,
        OP_ODD_ODD,
        OP_ODD2_PROD
    } op_t;

    typedef struct packed {
        logic                acc;
        logic                start;
        op_t                 op;
        logic                ax;
        logic                search_init;
        logic                save_x;
        logic                load_out;
        logic                clear;
        logic [STATUS_W-1:0] res_status;
    } pcc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic count_zero;
        logic var_zero;
        logic search_open;
        logic single;
    } pcc_sts_t;

endpackage
`default_nettype wire

// ===== sv/pcc_pair_if.sv =====
`default_nettype none
interface pcc_pair_if import pcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IN_COORD_W-1:0] meas_x;
    logic [IN_COORD_W-1:0] meas_y;
    logic [IN_COORD_W-1:0] ref_x;
    logic [IN_COORD_W-1:0] ref_y;
    logic                  last_pair;

    modport source (output valid, meas_x, meas_y, ref_x, ref_y, last_pair, input ready);
    modport sink   (input valid, meas_x, meas_y, ref_x, ref_y, last_pair, output ready);
endinterface
`default_nettype wire

// ===== sv/pcc_result_if.sv =====
`default_nettype none
interface pcc_result_if import pcc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SCORE_W-1:0]  score;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, score, status, input ready);
    modport sink   (input valid, score, status, output ready);
endinterface
`default_nettype wire

// ===== sv/pcc_cfg_if.sv =====
`default_nettype none
interface pcc_cfg_if import pcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/pcc_datapath.sv =====
`default_nettype none
module pcc_datapath import pcc_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IN_COORD_W-1:0]  meas_x,
    input  wire logic [IN_COORD_W-1:0]  meas_y,
    input  wire logic [IN_COORD_W-1:0]  ref_x,
    input  wire logic [IN_COORD_W-1:0]  ref_y,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire pcc_cmd_t               cmd,
    output pcc_sts_t                    sts,
    output logic signed [SCORE_W-1:0]   score,
    output logic [STATUS_W-1:0]         status
);

    localparam int C  = COORD_BITS;
    localparam int N  = COUNT_BITS;
    localparam int SW = C + N;
    localparam int QW = 2 * C + N;
    localparam int DW = 2 * C + 2 * N;
    localparam int PW = 2 * DW + ODD2_W;

    logic skip_reg, single_reg;

    logic [C-1:0]   mv [2];
    logic [C-1:0]   rv [2];
    logic           take;

    logic [N-1:0]   count_reg;
    logic           take_reg;
    logic [C-1:0]   m_reg  [2];
    logic [C-1:0]   r_reg  [2];
    logic [2*C-1:0] mm_reg [2];
    logic [2*C-1:0] rr_reg [2];
    logic [2*C-1:0] mr_reg [2];

    logic [SW-1:0]  sum_meas_reg    [2];
    logic [SW-1:0]  sum_ref_reg     [2];
    logic [QW-1:0]  sum_meas_sq_reg [2];
    logic [QW-1:0]  sum_ref_sq_reg  [2];
    logic [QW-1:0]  sum_cross_reg   [2];

    logic           busy_reg;
    op_t            op_reg;
    logic [PW-1:0]  a_reg, b_reg, p_reg;
    logic [PW-1:0]  a_next, b_next;
    logic [PW-1:0]  tmp_reg, prod_reg, lhs_reg;
    logic [DW-1:0]  d1_reg, d2_reg, mag_reg;
    logic           neg_reg;
    logic [SRCH_W-1:0] lo_reg, hi_reg;
    logic [SRCH_W:0]   lh_sum;
    logic [SRCH_W-1:0] mid;
    logic [SRCH_W:0]   odd;
    logic           done;

    logic signed [SCORE_W-1:0] sx_reg;
    logic signed [SCORE_W-1:0] axis_score;
    logic signed [SCORE_W:0]   s_sum, s_abs, s_half;
    logic signed [SCORE_W-1:0] avg_score;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg   <= 1'b0;
            single_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SKIP_ORIGIN: skip_reg   <= cfg_data[0];
                REG_SINGLE_AXIS: single_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign mv[0] = C'(meas_x);
    assign mv[1] = C'(meas_y);
    assign rv[0] = C'(ref_x);
    assign rv[1] = C'(ref_y);

    always_comb
    begin
        take = !(&count_reg);
        if (skip_reg && ((mv[0] == '0 && mv[1] == '0) || (rv[0] == '0 && rv[1] == '0)))
            take = 1'b0;
    end

    // First accumulation stage: count and products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            take_reg  <= 1'b0;
        end
        else
        begin
            take_reg <= cmd.acc && take;
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.acc && take)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            m_reg[i]  <= mv[i];
            r_reg[i]  <= rv[i];
            mm_reg[i] <= (2*C)'(mv[i]) * (2*C)'(mv[i]);
            rr_reg[i] <= (2*C)'(rv[i]) * (2*C)'(rv[i]);
            mr_reg[i] <= (2*C)'(mv[i]) * (2*C)'(rv[i]);
        end
    end

    // Second accumulation stage: the per-axis sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sum_meas_reg[i]    <= '0;
                sum_ref_reg[i]     <= '0;
                sum_meas_sq_reg[i] <= '0;
                sum_ref_sq_reg[i]  <= '0;
                sum_cross_reg[i]   <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sum_meas_reg[i]    <= '0;
                sum_ref_reg[i]     <= '0;
                sum_meas_sq_reg[i] <= '0;
                sum_ref_sq_reg[i]  <= '0;
                sum_cross_reg[i]   <= '0;
            end
        end
        else if (take_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sum_meas_reg[i]    <= sum_meas_reg[i] + SW'(m_reg[i]);
                sum_ref_reg[i]     <= sum_ref_reg[i] + SW'(r_reg[i]);
                sum_meas_sq_reg[i] <= sum_meas_sq_reg[i] + QW'(mm_reg[i]);
                sum_ref_sq_reg[i]  <= sum_ref_sq_reg[i] + QW'(rr_reg[i]);
                sum_cross_reg[i]   <= sum_cross_reg[i] + QW'(mr_reg[i]);
            end
        end
    end

    // Search midpoint and the odd value it tests.
    assign lh_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid    = lh_sum[SRCH_W:1];
    assign odd    = {mid, 1'b1};

    always_comb
    begin
        case (cmd.op)
            OP_N_SQM:     begin a_next = PW'(sum_meas_sq_reg[cmd.ax]); b_next = PW'(count_reg); end
            OP_SM_SM:     begin a_next = PW'(sum_meas_reg[cmd.ax]);    b_next = PW'(sum_meas_reg[cmd.ax]); end
            OP_N_SQR:     begin a_next = PW'(sum_ref_sq_reg[cmd.ax]);  b_next = PW'(count_reg); end
            OP_SR_SR:     begin a_next = PW'(sum_ref_reg[cmd.ax]);     b_next = PW'(sum_ref_reg[cmd.ax]); end
            OP_N_CROSS:   begin a_next = PW'(sum_cross_reg[cmd.ax]);   b_next = PW'(count_reg); end
            OP_SM_SR:     begin a_next = PW'(sum_meas_reg[cmd.ax]);    b_next = PW'(sum_ref_reg[cmd.ax]); end
            OP_D1_D2:     begin a_next = PW'(d1_reg);                  b_next = PW'(d2_reg); end
            OP_K_MAG:     begin a_next = PW'(mag_reg);                 b_next = PW'(SCALE2); end
            OP_T_T:       begin a_next = tmp_reg;                      b_next = tmp_reg; end
            OP_ODD_ODD:   begin a_next = PW'(odd);                     b_next = PW'(odd); end
            OP_ODD2_PROD: begin a_next = prod_reg;                     b_next = tmp_reg; end
            default:      begin a_next = '0;                           b_next = '0; end
        endcase
    end

    assign done = busy_reg && (b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= OP_N_SQM;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            op_reg   <= cmd.op;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Shift-and-add multiplier and the result handling of each job.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            p_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            if (b_reg[0])
                p_reg <= p_reg + a_reg;
            a_reg <= {a_reg[PW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[PW-1:1]};
        end

        if (cmd.search_init)
        begin
            lo_reg <= '0;
            hi_reg <= SRCH_W'(SEARCH_HI);
        end

        if (done)
        begin
            case (op_reg) inside
                OP_N_SQM, OP_N_SQR, OP_N_CROSS, OP_K_MAG, OP_ODD_ODD:
                    tmp_reg <= p_reg;
                OP_SM_SM:
                    d1_reg <= (tmp_reg > p_reg) ? DW'(tmp_reg - p_reg) : '0;
                OP_SR_SR:
                    d2_reg <= (tmp_reg > p_reg) ? DW'(tmp_reg - p_reg) : '0;
                OP_SM_SR:
                begin
                    neg_reg <= tmp_reg < p_reg;
                    mag_reg <= (tmp_reg < p_reg) ? DW'(p_reg - tmp_reg) : DW'(tmp_reg - p_reg);
                end
                OP_D1_D2:
                    prod_reg <= p_reg;
                OP_T_T:
                    lhs_reg <= p_reg;
                OP_ODD2_PROD:
                begin
                    if (p_reg <= lhs_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                end
                default: ;
            endcase
        end
    end

    assign axis_score = neg_reg ? -SCORE_W'(lo_reg) : SCORE_W'(lo_reg);

    // Average of the two axis scores, halves rounded away from zero.
    always_comb
    begin
        s_sum  = (SCORE_W+1)'(sx_reg) + (SCORE_W+1)'(axis_score);
        s_abs  = (s_sum < 0) ? -s_sum : s_sum;
        s_half = (s_abs + (SCORE_W+1)'(1)) >>> 1;
        avg_score = (s_sum < 0) ? -SCORE_W'(s_half) : SCORE_W'(s_half);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_x)
            sx_reg <= axis_score;
        if (cmd.load_out)
        begin
            status <= cmd.res_status;
            if (cmd.res_status != STATUS_OK)
                score <= '0;
            else if (single_reg)
                score <= sx_reg;
            else
                score <= avg_score;
        end
    end

    assign sts.mul_done    = done;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.var_zero    = (d1_reg == '0) || (d2_reg == '0);
    assign sts.search_open = lo_reg < hi_reg;
    assign sts.single      = single_reg;

endmodule
`default_nettype wire

// ===== sv/pcc_control.sv =====
`default_nettype none
module pcc_control import pcc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire pcc_sts_t sts,
    output pcc_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAIN,
        S_CHECK,
        S_START,
        S_WAIT,
        S_VCHK,
        S_SCHK,
        S_AXDONE,
        S_FIN
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic                ax_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.op          = op_reg;
        cmd.ax          = ax_reg;
        cmd.res_status  = res_status_reg;
        cmd.acc         = in_valid && (state_reg == S_IDLE);
        cmd.start       = (state_reg == S_START);
        cmd.search_init = (state_reg == S_WAIT) && sts.mul_done && (op_reg == OP_T_T);
        cmd.save_x      = (state_reg == S_AXDONE) && !ax_reg;
        cmd.load_out    = (state_reg == S_FIN) && !out_valid_reg;
        cmd.clear       = cmd.load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_N_SQM;
            ax_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_last)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (sts.count_zero)
                    begin
                        res_status_reg <= STATUS_EMPTY;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        ax_reg    <= 1'b0;
                        op_reg    <= OP_N_SQM;
                        state_reg <= S_START;
                    end
                end
                S_START:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (sts.mul_done)
                    begin
                        case (op_reg) inside
                            OP_SR_SR:             state_reg <= S_VCHK;
                            OP_T_T, OP_ODD2_PROD: state_reg <= S_SCHK;
                            default:
                            begin
                                op_reg    <= op_t'(op_reg + 1'b1);
                                state_reg <= S_START;
                            end
                        endcase
                    end
                end
                S_VCHK:
                begin
                    if (sts.var_zero)
                    begin
                        res_status_reg <= STATUS_FLAT;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        op_reg    <= OP_N_CROSS;
                        state_reg <= S_START;
                    end
                end
                S_SCHK:
                begin
                    if (sts.search_open)
                    begin
                        op_reg    <= OP_ODD_ODD;
                        state_reg <= S_START;
                    end
                    else
                        state_reg <= S_AXDONE;
                end
                S_AXDONE:
                begin
                    if (!ax_reg && !sts.single)
                    begin
                        ax_reg    <= 1'b1;
                        op_reg    <= OP_N_SQM;
                        state_reg <= S_START;
                    end
                    else
                    begin
                        res_status_reg <= STATUS_OK;
                        state_reg      <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/pearson_point_pair_correlation_top.sv =====
`default_nettype none
// Channel     Role    Handshake      Word
// pair_in     sink    valid/ready    meas_x, meas_y, ref_x, ref_y, last_pair
// result_out  source  valid/ready    score, status
// cfg         sink    valid/ready    index, data (always ready)
//
// While idle, a pair without last_pair is taken in the cycle it is offered. After a last
// pair one shift-and-add multiplier works out the coefficient, one multiplier bit per cycle;
// a multiply steps through the bits of its second operand up to the highest one set, and
// each axis runs the spread jobs and then up to 14 search steps.
// Reset clears all sums and both configuration registers at once.
// pair_in is held off from a last pair until its result word is loaded, which waits for
// any earlier word to leave result_out; a stall on result_out never loses a word.
module pearson_point_pair_correlation_top import pcc_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pcc_pair_if.sink     pair_in,
    pcc_result_if.source result_out,
    pcc_cfg_if.sink      cfg
);

    // The controller and the datapath meet only through these two structs.
    pcc_cmd_t cmd;
    pcc_sts_t sts;

    // Configuration is taken on any cycle, unchecked; users must only write it while idle.
    assign cfg.ready = 1'b1;

    pcc_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair_in.valid),
        .in_last   (pair_in.last_pair),
        .in_ready  (pair_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the sums, the serial multiplier, the score search
    // and the result word register.
    pcc_datapath #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas_x    (pair_in.meas_x),
        .meas_y    (pair_in.meas_y),
        .ref_x     (pair_in.ref_x),
        .ref_y     (pair_in.ref_y),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .sts       (sts),
        .score     (result_out.score),
        .status    (result_out.status)
    );

endmodule
`default_nettype wire

// ===== sv/pcc_checker.sv =====
`default_nettype none
module pcc_checker import pcc_pkg::*; (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      in_last,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [SCORE_W-1:0] score,
    input wire logic [STATUS_W-1:0]       status
);

    // A waiting result word stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(score) && $stable(status))
        else $error("result word changed while stalled");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> score >= -15'sd10000 && score <= 15'sd10000)
        else $error("score out of range");

    // A flagged result carries a zero score.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) ||
                      ((status == STATUS_EMPTY || status == STATUS_FLAT) && score == '0))
        else $error("bad status or nonzero score with a flag");

    // The run closes on a last pair: no further pair enters on the next cycle.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("pair taken right after a last pair");

endmodule

bind pearson_point_pair_correlation_top pcc_checker u_pcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pair_in.valid),
    .in_ready  (pair_in.ready),
    .in_last   (pair_in.last_pair),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .score     (result_out.score),
    .status    (result_out.status)
);
`default_nettype wire
